// ===== src/lbfs_pkg.sv =====
// Package for the line byte/field selector: shared types, register indexes
// and reset constants. No dependencies; used by every module of the block.
`default_nettype none

package lbfs_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 33;
    localparam int RANGE_W     = 33;

    // Range register packing
    localparam int RANGE_LO_LSB  = 0;
    localparam int RANGE_HI_LSB  = 16;
    localparam int RANGE_OPEN_BIT = 32;
    localparam int RANGE_POS_W   = 16;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CUT_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIMITER   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEED_DELIM  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_COUNT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_0     = 3'd4;

    // Reset values
    localparam logic [7:0]         DELIM_RESET       = 8'h09;
    localparam logic [2:0]         RANGE_COUNT_RESET = 3'd1;
    localparam logic [RANGE_W-1:0] RANGE0_RESET      = 33'h1_0000_0001;

    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    typedef struct packed {
        logic       cut_mode;     // 0 fields, 1 bytes
        logic [7:0] delimiter;
        logic       need_delim;
        logic [2:0] range_count;
    } cfg_t;

    // Non-flush part of the results caused by one word
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] byte_val;
        logic       newline;
        logic       overflow;
    } rec_t;

endpackage

`default_nettype wire

// ===== src/line_byte_field_selector_core.sv =====
// Top level of the line byte/field selector (cut -b/-c/-f style selection).
// Depends on lbfs_pkg, lbfs_cfg_regs, lbfs_line_ctrl and lbfs_emit.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_ready   | text_byte, byte_present, line_end
//  out     | out_valid / out_ready | out_byte, is_newline, hold_overflow,
//          |                       | last_of_run
//  cfg     | cfg_we                | cfg_index, cfg_data
//
// While the output does not stall: one input word per cycle while each word
// causes at most one result word; results go out in turn, held field-1 bytes
// one a cycle from the hold shift line, then the kept byte, then the newline.
// A word passes the input register, pending record and output register.
// Reset clears control and line state; the hold store needs no clearing pass.
// A stalled output keeps one pending record and one input word buffered.
`default_nettype none

module line_byte_field_selector_core #(
    parameter int NUM_RANGES = 4,
    parameter int HOLD_DEPTH = 32,
    parameter int POS_BITS   = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [7:0]                         text_byte,
    input  wire logic                               byte_present,
    input  wire logic                               line_end,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [7:0]                              out_byte,
    output logic                                    is_newline,
    output logic                                    hold_overflow,
    output logic                                    last_of_run,
    input  wire logic                               cfg_we,
    input  wire logic [lbfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [lbfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int HCW = $clog2(HOLD_DEPTH + 1);
    localparam int HAW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    lbfs_pkg::cfg_t                              cfg;
    logic [NUM_RANGES-1:0][lbfs_pkg::RANGE_W-1:0] ranges;
    lbfs_pkg::rec_t                              rec;
    logic                                        rec_load;
    logic                                        pend_free;
    logic [HCW-1:0]                              flush_n;
    logic                                        hold_we;
    logic [HAW-1:0]                              hold_addr;
    logic [7:0]                                  hold_data;

    lbfs_cfg_regs #(
        .NUM_RANGES (NUM_RANGES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .ranges    (ranges)
    );

    lbfs_line_ctrl #(
        .NUM_RANGES (NUM_RANGES),
        .HOLD_DEPTH (HOLD_DEPTH),
        .POS_BITS   (POS_BITS)
    ) u_line (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .text_byte    (text_byte),
        .byte_present (byte_present),
        .line_end     (line_end),
        .cfg          (cfg),
        .ranges       (ranges),
        .pend_free    (pend_free),
        .rec_load     (rec_load),
        .rec          (rec),
        .flush_n      (flush_n),
        .hold_we      (hold_we),
        .hold_addr    (hold_addr),
        .hold_data    (hold_data)
    );

    lbfs_emit #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_load      (rec_load),
        .rec           (rec),
        .flush_n       (flush_n),
        .hold_we       (hold_we),
        .hold_addr     (hold_addr),
        .hold_data     (hold_data),
        .pend_free     (pend_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .is_newline    (is_newline),
        .hold_overflow (hold_overflow),
        .last_of_run   (last_of_run)
    );

endmodule

`default_nettype wire

// ===== src/lbfs_cfg_regs.sv =====
// Configuration register file of the line byte/field selector.
// Depends on lbfs_pkg for register indexes, widths and reset values.
`default_nettype none

module lbfs_cfg_regs #(
    parameter int NUM_RANGES = 4
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [lbfs_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [lbfs_pkg::CFG_DATA_W-1:0]        cfg_data,
    output lbfs_pkg::cfg_t                              cfg,
    output logic [NUM_RANGES-1:0][lbfs_pkg::RANGE_W-1:0] ranges
);

    lbfs_pkg::cfg_t                              cfg_reg;
    logic [NUM_RANGES-1:0][lbfs_pkg::RANGE_W-1:0] ranges_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cut_mode    <= 1'b0;
            cfg_reg.delimiter   <= lbfs_pkg::DELIM_RESET;
            cfg_reg.need_delim  <= 1'b0;
            cfg_reg.range_count <= lbfs_pkg::RANGE_COUNT_RESET;
            for (int k = 0; k < NUM_RANGES; k++)
            begin
                ranges_reg[k] <= (k == 0) ? lbfs_pkg::RANGE0_RESET : '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lbfs_pkg::CFG_CUT_MODE:    cfg_reg.cut_mode    <= cfg_data[0];
                lbfs_pkg::CFG_DELIMITER:   cfg_reg.delimiter   <= cfg_data[7:0];
                lbfs_pkg::CFG_NEED_DELIM:  cfg_reg.need_delim  <= cfg_data[0];
                lbfs_pkg::CFG_RANGE_COUNT: cfg_reg.range_count <= cfg_data[2:0];
                default:
                begin
                    // Range registers; indexes past the built ranges are dropped
                    for (int k = 0; k < NUM_RANGES; k++)
                    begin
                        if (cfg_index == lbfs_pkg::CFG_RANGE_0
                                         + lbfs_pkg::CFG_INDEX_W'(k))
                        begin
                            ranges_reg[k] <= cfg_data[lbfs_pkg::RANGE_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    assign cfg    = cfg_reg;
    assign ranges = ranges_reg;

endmodule

`default_nettype wire

// ===== src/lbfs_range_match.sv =====
// Parallel range compare: is a 1-based position inside any active range.
// Depends on lbfs_pkg for the range register packing.
`default_nettype none

module lbfs_range_match #(
    parameter int NUM_RANGES = 4,
    parameter int POS_BITS   = 16
) (
    input  wire logic [POS_BITS-1:0]                        pos,
    input  wire logic [2:0]                                 range_count,
    input  wire logic [NUM_RANGES-1:0][lbfs_pkg::RANGE_W-1:0] ranges,
    output logic                                            wanted
);

    localparam int CW = (POS_BITS > lbfs_pkg::RANGE_POS_W) ? POS_BITS
                                                           : lbfs_pkg::RANGE_POS_W;

    always_comb
    begin
        logic [CW-1:0] p;
        logic [CW-1:0] lo;
        logic [CW-1:0] hi;
        logic          hit;
        hit = 1'b0;
        p   = CW'(pos);
        for (int k = 0; k < NUM_RANGES; k++)
        begin
            lo = CW'(ranges[k][lbfs_pkg::RANGE_LO_LSB +: lbfs_pkg::RANGE_POS_W]);
            hi = CW'(ranges[k][lbfs_pkg::RANGE_HI_LSB +: lbfs_pkg::RANGE_POS_W]);
            // A count above the built ranges simply enables all of them
            if ((3'(k) < range_count) && (p >= lo)
                && (ranges[k][lbfs_pkg::RANGE_OPEN_BIT] || (p <= hi)))
            begin
                hit = 1'b1;
            end
        end
        wanted = hit;
    end

endmodule

`default_nettype wire

// ===== src/lbfs_line_ctrl.sv =====
// Input register and per-line state: position counting, delimiter tracking,
// hold bookkeeping and the result record for each word.
// Depends on lbfs_pkg and lbfs_range_match.
`default_nettype none

module lbfs_line_ctrl #(
    parameter int NUM_RANGES = 4,
    parameter int HOLD_DEPTH = 32,
    parameter int POS_BITS   = 16,
    localparam int HCW = $clog2(HOLD_DEPTH + 1),
    localparam int HAW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [7:0]                             text_byte,
    input  wire logic                                   byte_present,
    input  wire logic                                   line_end,
    input  lbfs_pkg::cfg_t                              cfg,
    input  wire logic [NUM_RANGES-1:0][lbfs_pkg::RANGE_W-1:0] ranges,
    input  wire logic                                   pend_free,
    output logic                                        rec_load,
    output lbfs_pkg::rec_t                              rec,
    output logic [HCW-1:0]                              flush_n,
    output logic                                        hold_we,
    output logic [HAW-1:0]                              hold_addr,
    output logic [7:0]                                  hold_data
);

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    logic                in_valid_reg, in_valid_next;
    logic [7:0]          in_byte_reg;
    logic                in_present_reg;
    logic                in_last_reg;

    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic                emitted_reg, emitted_next;
    logic                dseen_reg, dseen_next;
    logic [HCW-1:0]      hcount_reg, hcount_next;
    logic                ovf_reg, ovf_next;

    logic                in_take;
    logic                accept;
    logic [POS_BITS-1:0] pos_inc;
    logic                wanted_cur;
    logic                wanted_inc;
    logic                field_mode;
    logic                holding;
    logic                is_delim;
    logic                dseen_new;
    logic                emitted_new;
    logic                drop;
    logic                do_flush;
    logic                hold_hit;
    logic                hold_ok;
    logic                hold_full;
    logic                pos_adv;

    assign in_take  = in_valid_reg && pend_free;
    assign in_ready = !in_valid_reg || in_take;
    assign accept   = in_valid && in_ready;

    assign in_valid_next = accept ? 1'b1 : (in_take ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg    <= text_byte;
            in_present_reg <= byte_present;
            in_last_reg    <= line_end;
        end
    end

    assign pos_inc = (pos_reg != POS_MAX) ? pos_reg + POS_BITS'(1) : pos_reg;

    lbfs_range_match #(
        .NUM_RANGES (NUM_RANGES),
        .POS_BITS   (POS_BITS)
    ) u_match_cur (
        .pos         (pos_reg),
        .range_count (cfg.range_count),
        .ranges      (ranges),
        .wanted      (wanted_cur)
    );

    lbfs_range_match #(
        .NUM_RANGES (NUM_RANGES),
        .POS_BITS   (POS_BITS)
    ) u_match_inc (
        .pos         (pos_inc),
        .range_count (cfg.range_count),
        .ranges      (ranges),
        .wanted      (wanted_inc)
    );

    always_comb
    begin
        field_mode  = !cfg.cut_mode;
        holding     = field_mode && cfg.need_delim && !dseen_reg;
        is_delim    = in_present_reg && field_mode && (in_byte_reg == cfg.delimiter);
        dseen_new   = dseen_reg || is_delim;
        emitted_new = emitted_reg || (is_delim && wanted_cur);
        drop        = in_last_reg && field_mode && cfg.need_delim && !dseen_new;
        // Held bytes always go out ahead of anything else this word causes
        do_flush    = (hcount_reg != '0)
                      && (!holding || is_delim || (in_last_reg && !drop));
        hold_hit    = in_present_reg && !is_delim && wanted_cur && holding;
        hold_ok     = hold_hit && (hcount_reg < HCW'(HOLD_DEPTH));
        hold_full   = hold_hit && !(hcount_reg < HCW'(HOLD_DEPTH));
        pos_adv     = is_delim || (in_present_reg && !field_mode);

        rec.overflow = ovf_reg;
        rec.newline  = in_last_reg && !drop;
        if (is_delim)
        begin
            rec.byte_valid = wanted_inc && emitted_new;
            rec.byte_val   = cfg.delimiter;
        end
        else
        begin
            rec.byte_valid = in_present_reg && wanted_cur && !holding;
            rec.byte_val   = in_byte_reg;
        end
        flush_n = do_flush ? hcount_reg : '0;

        if (in_last_reg)
        begin
            pos_next     = POS_BITS'(1);
            emitted_next = 1'b0;
            dseen_next   = 1'b0;
            hcount_next  = '0;
            ovf_next     = 1'b0;
        end
        else
        begin
            pos_next     = pos_adv ? pos_inc : pos_reg;
            emitted_next = emitted_new;
            dseen_next   = dseen_new;
            hcount_next  = do_flush ? '0 : (hold_ok ? hcount_reg + HCW'(1) : hcount_reg);
            ovf_next     = ovf_reg || hold_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_BITS'(1);
            emitted_reg <= 1'b0;
            dseen_reg   <= 1'b0;
            hcount_reg  <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (in_take)
        begin
            pos_reg     <= pos_next;
            emitted_reg <= emitted_next;
            dseen_reg   <= dseen_next;
            hcount_reg  <= hcount_next;
            ovf_reg     <= ovf_next;
        end
    end

    assign rec_load  = in_take;
    assign hold_we   = in_take && hold_ok;
    assign hold_addr = hcount_reg[HAW-1:0];
    assign hold_data = in_byte_reg;

endmodule

`default_nettype wire

// ===== src/lbfs_emit.sv =====
// Result sequencer: pending record, hold store shift line and the output
// register. Sends held bytes, then the kept byte, then the newline.
// Depends on lbfs_pkg.
`default_nettype none

module lbfs_emit #(
    parameter int HOLD_DEPTH = 32,
    localparam int HCW = $clog2(HOLD_DEPTH + 1),
    localparam int HAW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           rec_load,
    input  lbfs_pkg::rec_t      rec,
    input  wire logic [HCW-1:0] flush_n,
    input  wire logic           hold_we,
    input  wire logic [HAW-1:0] hold_addr,
    input  wire logic [7:0]     hold_data,
    output logic                pend_free,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_byte,
    output logic                is_newline,
    output logic                hold_overflow,
    output logic                last_of_run
);

    logic [7:0]     hold_reg [HOLD_DEPTH];
    logic [7:0]     shift_src [HOLD_DEPTH+1];

    lbfs_pkg::rec_t pend_reg, pend_next;
    logic [HCW-1:0] flush_left_reg, flush_left_next;

    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_byte_reg, out_byte_next;
    logic           is_newline_reg, is_newline_next;
    logic           hold_overflow_reg;
    logic           last_of_run_reg, last_of_run_next;

    logic           out_load;
    logic           pend_any;
    logic           pend_one;
    logic           emit;
    logic           shift;

    assign out_load = !out_valid_reg || out_ready;
    assign pend_any = (flush_left_reg != '0) || pend_reg.byte_valid || pend_reg.newline;
    assign pend_one = ((flush_left_reg == HCW'(1)) && !pend_reg.byte_valid && !pend_reg.newline)
                      || ((flush_left_reg == '0) && (pend_reg.byte_valid != pend_reg.newline));
    assign emit      = out_load && pend_any;
    assign pend_free = !pend_any || (out_load && pend_one);

    always_comb
    begin
        pend_next        = pend_reg;
        flush_left_next  = flush_left_reg;
        shift            = 1'b0;
        out_byte_next    = out_byte_reg;
        is_newline_next  = is_newline_reg;
        last_of_run_next = last_of_run_reg;

        if (emit)
        begin
            if (flush_left_reg != '0)
            begin
                out_byte_next    = hold_reg[0];
                is_newline_next  = 1'b0;
                last_of_run_next = (flush_left_reg == HCW'(1))
                                   && !pend_reg.byte_valid && !pend_reg.newline;
                flush_left_next  = flush_left_reg - HCW'(1);
                shift            = 1'b1;
            end
            else if (pend_reg.byte_valid)
            begin
                out_byte_next        = pend_reg.byte_val;
                is_newline_next      = 1'b0;
                last_of_run_next     = !pend_reg.newline;
                pend_next.byte_valid = 1'b0;
            end
            else
            begin
                out_byte_next     = lbfs_pkg::NEWLINE_CHAR;
                is_newline_next   = 1'b1;
                last_of_run_next  = 1'b1;
                pend_next.newline = 1'b0;
            end
        end

        // A new record lands only when none is pending or the current one finishes this cycle
        if (rec_load)
        begin
            pend_next       = rec;
            flush_left_next = flush_n;
        end

        out_valid_next = emit ? 1'b1 : (out_load ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            flush_left_reg <= '0;
            pend_reg       <= '0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            flush_left_reg <= flush_left_next;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg      <= out_byte_next;
        is_newline_reg    <= is_newline_next;
        last_of_run_reg   <= last_of_run_next;
        if (emit)
        begin
            hold_overflow_reg <= pend_reg.overflow;
        end
    end

    // Hold store: written at the fill index, read at entry 0, shifted down
    always_comb
    begin
        for (int i = 0; i < HOLD_DEPTH; i++)
        begin
            shift_src[i] = hold_reg[i];
        end
        shift_src[HOLD_DEPTH] = 8'h00;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HOLD_DEPTH; i++)
        begin
            if (hold_we && (hold_addr == HAW'(i)))
            begin
                hold_reg[i] <= hold_data;
            end
            else if (shift)
            begin
                hold_reg[i] <= shift_src[i+1];
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign is_newline    = is_newline_reg;
    assign hold_overflow = hold_overflow_reg;
    assign last_of_run   = last_of_run_reg;

endmodule

`default_nettype wire

// ===== src/lbfs_port_checker.sv =====
// Port-level checks for the line byte/field selector output channel,
// bound to line_byte_field_selector_core. Depends on lbfs_pkg.
`default_nettype none

module lbfs_port_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       is_newline,
    input wire logic       hold_overflow,
    input wire logic       last_of_run
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(is_newline) && $stable(hold_overflow) && $stable(last_of_run))
        else $error("output word changed while stalled");

    // A newline always closes the results of its input word
    a_nl_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_newline |-> last_of_run)
        else $error("newline word without last_of_run");

    a_nl_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_newline |-> out_byte == lbfs_pkg::NEWLINE_CHAR)
        else $error("newline word carries wrong byte");

    // The rest of a run follows without a gap
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("gap inside a run of result words");

endmodule

bind line_byte_field_selector_core lbfs_port_checker u_port_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .is_newline    (is_newline),
    .hold_overflow (hold_overflow),
    .last_of_run   (last_of_run)
);

`default_nettype wire
